### rtl/fct_pkg.sv
// ----------------------------------------------------------------------------
// Frustum cull test package
// Shared types and constants for the six-plane culling datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package fct_pkg;

  localparam int PLANE_COUNT = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int COEF_W      = 16;

  // D is an integer, the products carry 8 + 14 fraction bits.
  localparam int D_SHIFT   = 22;
  // The radius carries 8 fraction bits and needs 14 more to match.
  localparam int RAD_SHIFT = 14;

  typedef enum logic [1:0] {
    MODE_POINT  = 2'd0,
    MODE_SPHERE = 2'd1,
    MODE_BOX    = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANE_LEFT   = 3'd0,
    REG_PLANE_RIGHT  = 3'd1,
    REG_PLANE_TOP    = 3'd2,
    REG_PLANE_BOTTOM = 3'd3,
    REG_PLANE_NEAR   = 3'd4,
    REG_PLANE_FAR    = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] d;
    logic signed [COEF_W-1:0] nz;
    logic signed [COEF_W-1:0] ny;
    logic signed [COEF_W-1:0] nx;
  } plane_t;

endpackage : fct_pkg

`default_nettype wire

### rtl/fct_if.sv
// ----------------------------------------------------------------------------
// Frustum cull test channels
// Valid/ready channels for the input items, the results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface fct_in_if #(
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   mode;
  logic signed [COORD_BITS-1:0] corner_a_x;
  logic signed [COORD_BITS-1:0] corner_a_y;
  logic signed [COORD_BITS-1:0] corner_a_z;
  logic signed [COORD_BITS-1:0] corner_b_x;
  logic signed [COORD_BITS-1:0] corner_b_y;
  logic signed [COORD_BITS-1:0] corner_b_z;
  logic [COORD_BITS-2:0]        radius;

  modport source (
    output valid, mode, corner_a_x, corner_a_y, corner_a_z,
           corner_b_x, corner_b_y, corner_b_z, radius,
    input  ready
  );
  modport sink (
    input  valid, mode, corner_a_x, corner_a_y, corner_a_z,
           corner_b_x, corner_b_y, corner_b_z, radius,
    output ready
  );
endinterface : fct_in_if

interface fct_out_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink   (input valid, inside_res, output ready);
endinterface : fct_out_if

interface fct_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fct_pkg::CFG_IDX_W-1:0]   index;
  logic [fct_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface : fct_cfg_if

`default_nettype wire

### rtl/fct_plane_regs.sv
// ----------------------------------------------------------------------------
// Frustum cull plane registers
// Holds the six plane coefficient sets written through the register port.
// ----------------------------------------------------------------------------
`default_nettype none

module fct_plane_regs (
  input  wire logic            clk,
  input  wire logic            rst_n,
  fct_cfg_if.sink              cfg_ch,
  output fct_pkg::plane_t      planes [fct_pkg::PLANE_COUNT]
);

  fct_pkg::plane_t plane_r [fct_pkg::PLANE_COUNT];

  assign cfg_ch.ready = 1'b1;

  // Writes to an index beyond the far plane are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < fct_pkg::PLANE_COUNT; i++) begin
        plane_r[i] <= '0;
      end
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        fct_pkg::REG_PLANE_LEFT:   plane_r[0] <= fct_pkg::plane_t'(cfg_ch.data);
        fct_pkg::REG_PLANE_RIGHT:  plane_r[1] <= fct_pkg::plane_t'(cfg_ch.data);
        fct_pkg::REG_PLANE_TOP:    plane_r[2] <= fct_pkg::plane_t'(cfg_ch.data);
        fct_pkg::REG_PLANE_BOTTOM: plane_r[3] <= fct_pkg::plane_t'(cfg_ch.data);
        fct_pkg::REG_PLANE_NEAR:   plane_r[4] <= fct_pkg::plane_t'(cfg_ch.data);
        fct_pkg::REG_PLANE_FAR:    plane_r[5] <= fct_pkg::plane_t'(cfg_ch.data);
        default: ;
      endcase
    end
  end

  assign planes = plane_r;

endmodule : fct_plane_regs

`default_nettype wire

### rtl/fct_plane_lane.sv
// ----------------------------------------------------------------------------
// Frustum cull plane lane
// Signed distance of a point, sphere or box against one plane.
// ----------------------------------------------------------------------------
`default_nettype none

module fct_plane_lane #(
  parameter int COORD_BITS = 24,
  parameter int SUM_W      = 42
) (
  input  wire fct_pkg::plane_t        plane,
  input  wire logic                   is_box,
  input  wire logic signed [COORD_BITS-1:0] a_x,
  input  wire logic signed [COORD_BITS-1:0] a_y,
  input  wire logic signed [COORD_BITS-1:0] a_z,
  input  wire logic signed [COORD_BITS-1:0] b_x,
  input  wire logic signed [COORD_BITS-1:0] b_y,
  input  wire logic signed [COORD_BITS-1:0] b_z,
  input  wire logic signed [SUM_W-1:0]      thresh,
  output logic                        reject
);

  localparam int PROD_W = COORD_BITS + fct_pkg::COEF_W;

  logic signed [PROD_W-1:0] pa_x, pa_y, pa_z, pb_x, pb_y, pb_z;
  logic signed [PROD_W-1:0] t_x, t_y, t_z;
  logic signed [SUM_W-1:0]  d_term;
  logic signed [SUM_W-1:0]  dist_sum;

  assign pa_x = plane.nx * a_x;
  assign pa_y = plane.ny * a_y;
  assign pa_z = plane.nz * a_z;
  assign pb_x = plane.nx * b_x;
  assign pb_y = plane.ny * b_y;
  assign pb_z = plane.nz * b_z;

  // The farthest box corner along the normal takes, per axis, the larger
  // of the two products; if even that corner is not inside, all eight fail.
  assign t_x = (is_box && (pb_x > pa_x)) ? pb_x : pa_x;
  assign t_y = (is_box && (pb_y > pa_y)) ? pb_y : pa_y;
  assign t_z = (is_box && (pb_z > pa_z)) ? pb_z : pa_z;

  assign d_term = SUM_W'(plane.d) <<< fct_pkg::D_SHIFT;

  assign dist_sum = SUM_W'(t_x) + SUM_W'(t_y) + SUM_W'(t_z) + d_term + thresh;

  assign reject = dist_sum[SUM_W-1] || (dist_sum == '0);

endmodule : fct_plane_lane

`default_nettype wire

### rtl/frustum_cull_test.sv
// ----------------------------------------------------------------------------
// Frustum cull test
// Tests a point, sphere or box against six stored frustum planes.
// ----------------------------------------------------------------------------
// An accepted input beat passes the input register, then the result register.
// Throughput: one item per cycle unless out_ch stalls; the six plane lanes all
// work in parallel between the input register and the result register.
// Reset: synchronous, active low; clears the pipeline valid bits and all six
// plane registers to zero.
`default_nettype none

module frustum_cull_test #(
  parameter int COORD_BITS = 24
) (
  input  wire logic clk,
  input  wire logic rst_n,
  fct_in_if.sink    in_ch,
  fct_out_if.source out_ch,
  fct_cfg_if.sink   cfg_ch
);

  localparam int PROD_W = COORD_BITS + fct_pkg::COEF_W;
  localparam int BASE_W = (PROD_W > fct_pkg::COEF_W + fct_pkg::D_SHIFT) ?
                          PROD_W : (fct_pkg::COEF_W + fct_pkg::D_SHIFT);
  localparam int SUM_W  = BASE_W + 2;

  fct_pkg::plane_t planes [fct_pkg::PLANE_COUNT];

  logic                         s1_valid_r;
  logic [1:0]                   mode_r;
  logic signed [COORD_BITS-1:0] a_x_r, a_y_r, a_z_r, b_x_r, b_y_r, b_z_r;
  logic [COORD_BITS-2:0]        rad_r;

  logic                         out_valid_r;
  logic                         inside_r;
  logic                         inside_nxt;

  logic                         s2_take;
  logic                         s1_take;
  logic                         is_box;
  logic                         is_sphere;
  logic signed [SUM_W-1:0]      thresh;
  logic [fct_pkg::PLANE_COUNT-1:0] reject;

  fct_plane_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .planes (planes)
  );

  assign s2_take     = !out_valid_r || out_ch.ready;
  assign s1_take     = !s1_valid_r || s2_take;
  assign in_ch.ready = s1_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_take) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && in_ch.valid) begin
      mode_r <= in_ch.mode;
      a_x_r  <= in_ch.corner_a_x;
      a_y_r  <= in_ch.corner_a_y;
      a_z_r  <= in_ch.corner_a_z;
      b_x_r  <= in_ch.corner_b_x;
      b_y_r  <= in_ch.corner_b_y;
      b_z_r  <= in_ch.corner_b_z;
      rad_r  <= in_ch.radius;
    end
  end

  // The unused mode code falls through to the point test.
  assign is_box    = (mode_r == fct_pkg::MODE_BOX);
  assign is_sphere = (mode_r == fct_pkg::MODE_SPHERE);

  // A sphere survives a plane while distance + radius stays above zero.
  assign thresh = is_sphere ?
                  ($signed({{(SUM_W-COORD_BITS+1){1'b0}}, rad_r}) <<< fct_pkg::RAD_SHIFT) :
                  '0;

  for (genvar p = 0; p < fct_pkg::PLANE_COUNT; p++) begin : g_lane
    fct_plane_lane #(
      .COORD_BITS (COORD_BITS),
      .SUM_W      (SUM_W)
    ) u_lane (
      .plane  (planes[p]),
      .is_box (is_box),
      .a_x    (a_x_r),
      .a_y    (a_y_r),
      .a_z    (a_z_r),
      .b_x    (b_x_r),
      .b_y    (b_y_r),
      .b_z    (b_z_r),
      .thresh (thresh),
      .reject (reject[p])
    );
  end

  assign inside_nxt = ~|reject;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_take) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take && s1_valid_r) begin
      inside_r <= inside_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.inside_res = inside_r;

endmodule : frustum_cull_test

`default_nettype wire

### tb/frustum_cull_test_tb.sv
// ----------------------------------------------------------------------------
// Frustum cull test bench
// Sends point, sphere and box queries through the six-plane culling block
// under several plane settings: zero planes, an axis-aligned cube, the
// coefficient extremes and random planes. The inside bit of every accepted
// query is worked out here and checked against the result channel, while
// both sides of the block idle and stall at random.
// ----------------------------------------------------------------------------
module frustum_cull_test_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB           = 24;
  localparam int RB           = CB - 1;
  localparam int UNIT         = 256;          // one whole unit in Q16.8
  localparam int NEAR_SPAN    = 160 * UNIT;
  localparam int COORD_MAX    = 2 ** (CB - 1) - 1;
  localparam int COORD_MIN    = -(2 ** (CB - 1));
  localparam int RAD_MAX      = 2 ** RB - 1;
  localparam int CORNERS      = 8;
  localparam int COEF_ONE     = 16384;        // 1.0 in Q1.14
  localparam int CUBE_HALF    = 100;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_CYCLES = 80;
  localparam int STALL_AT_A   = 60;
  localparam int STALL_AT_B   = 400;

  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam logic [fct_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [fct_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  localparam logic [fct_pkg::CFG_DATA_W-1:0] PLANE_ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [fct_pkg::CFG_DATA_W-1:0] PLANE_ALL_MAX  = 64'h7FFF_7FFF_7FFF_7FFF;
  localparam logic [fct_pkg::CFG_DATA_W-1:0] PLANE_ALL_MIN  = 64'h8000_8000_8000_8000;

  typedef struct {
    logic [1:0]           mode;
    logic signed [CB-1:0] corner_a_x, corner_a_y, corner_a_z;
    logic signed [CB-1:0] corner_b_x, corner_b_y, corner_b_z;
    logic [RB-1:0]        radius;
  } cull_query_t;

  logic clk = 1'b0;
  logic rst_n;

  fct_in_if #(.COORD_BITS(CB)) in_bus ();
  fct_out_if                   out_bus ();
  fct_cfg_if                   cfg_bus ();

  fct_pkg::plane_t frustum[fct_pkg::PLANE_COUNT];
  cull_query_t     queries_to_send[$];
  bit              inside_due[$];
  bit              offer_open = 1'b0;
  int unsigned     fail_count = 0;
  int unsigned     results_seen = 0;

  frustum_cull_test #(.COORD_BITS(CB)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  always #10 clk = ~clk;

  function automatic longint plane_distance(fct_pkg::plane_t pl, longint x, longint y,
                                            longint z);
    return longint'(pl.nx) * x + longint'(pl.ny) * y + longint'(pl.nz) * z
         + (longint'(pl.d) <<< fct_pkg::D_SHIFT);
  endfunction

  function automatic bit frustum_verdict(cull_query_t q);
    longint ax      = q.corner_a_x;
    longint ay      = q.corner_a_y;
    longint az      = q.corner_a_z;
    longint bx      = q.corner_b_x;
    longint by      = q.corner_b_y;
    longint bz      = q.corner_b_z;
    longint rad_q22 = longint'(q.radius) <<< fct_pkg::RAD_SHIFT;
    bit     verdict = 1'b1;
    bit     any_pos;
    for (int p = 0; p < fct_pkg::PLANE_COUNT; p++) begin
      case (q.mode)
        fct_pkg::MODE_SPHERE: begin
          if (plane_distance(frustum[p], ax, ay, az) <= -rad_q22) verdict = 1'b0;
        end
        fct_pkg::MODE_BOX: begin
          // A box survives a plane as long as one of its corners is in front.
          any_pos = 1'b0;
          for (int c = 0; c < CORNERS; c++) begin
            if (plane_distance(frustum[p], c[0] ? bx : ax, c[1] ? by : ay,
                               c[2] ? bz : az) > 0) any_pos = 1'b1;
          end
          if (!any_pos) verdict = 1'b0;
        end
        default: begin
          if (plane_distance(frustum[p], ax, ay, az) <= 0) verdict = 1'b0;
        end
      endcase
    end
    return verdict;
  endfunction

  function automatic cull_query_t make_query(logic [1:0] mode, int ax, int ay, int az,
                                             int bx, int by, int bz, int radius);
    cull_query_t q;
    q.mode       = mode;
    q.corner_a_x = CB'(ax);
    q.corner_a_y = CB'(ay);
    q.corner_a_z = CB'(az);
    q.corner_b_x = CB'(bx);
    q.corner_b_y = CB'(by);
    q.corner_b_z = CB'(bz);
    q.radius     = RB'(radius);
    return q;
  endfunction

  function automatic logic signed [CB-1:0] rand_coord();
    if ($urandom_range(0, 3) == 0) return CB'($urandom);
    return CB'(int'($urandom_range(0, 2 * NEAR_SPAN)) - NEAR_SPAN);
  endfunction

  function automatic logic [RB-1:0] rand_radius();
    if ($urandom_range(0, 3) == 0) return RB'($urandom);
    return RB'($urandom_range(0, 80 * UNIT));
  endfunction

  function automatic cull_query_t rand_query();
    cull_query_t q;
    int unsigned pick = $urandom_range(0, 9);
    if (pick < 3)      q.mode = fct_pkg::MODE_POINT;
    else if (pick < 6) q.mode = fct_pkg::MODE_SPHERE;
    else if (pick < 9) q.mode = fct_pkg::MODE_BOX;
    else               q.mode = MODE_SPARE;
    q.corner_a_x = rand_coord();
    q.corner_a_y = rand_coord();
    q.corner_a_z = rand_coord();
    q.corner_b_x = rand_coord();
    q.corner_b_y = rand_coord();
    q.corner_b_z = rand_coord();
    q.radius     = rand_radius();
    return q;
  endfunction

  // Left/right bound x, top/bottom y and near/far z. Even planes face the
  // positive direction of their axis and odd ones the negative.
  function automatic fct_pkg::plane_t cube_plane(int k, int half_units, int mag);
    fct_pkg::plane_t                   pl   = '0;
    logic signed [fct_pkg::COEF_W-1:0] comp = (k % 2 == 0) ? fct_pkg::COEF_W'(mag) :
                                                             fct_pkg::COEF_W'(-mag);
    case (k / 2)
      0:       pl.nx = comp;
      1:       pl.ny = comp;
      default: pl.nz = comp;
    endcase
    pl.d = fct_pkg::COEF_W'(half_units);
    return pl;
  endfunction

  function automatic fct_pkg::plane_t rand_plane(int k);
    fct_pkg::plane_t pl;
    int unsigned     pick = $urandom_range(0, 7);
    if (pick == 0) return '0;
    if (pick < 3) return fct_pkg::plane_t'({$urandom, $urandom});
    pl    = cube_plane(k, $urandom_range(1, 300), $urandom_range(4096, 16383));
    pl.nx = pl.nx + fct_pkg::COEF_W'($urandom_range(0, 3000)) - fct_pkg::COEF_W'(1500);
    pl.ny = pl.ny + fct_pkg::COEF_W'($urandom_range(0, 3000)) - fct_pkg::COEF_W'(1500);
    pl.nz = pl.nz + fct_pkg::COEF_W'($urandom_range(0, 3000)) - fct_pkg::COEF_W'(1500);
    return pl;
  endfunction

  // Gaps come in runs: some runs idle at random, others not at all.
  function automatic int unsigned pick_gap(ref int unsigned run_left, ref bit idling);
    if (run_left == 0) begin
      run_left = $urandom_range(10, 40);
      idling   = ($urandom_range(0, 2) != 0);
    end
    run_left--;
    return idling ? $urandom_range(0, 11) : 0;
  endfunction

  task automatic write_plane(logic [fct_pkg::CFG_IDX_W-1:0] idx,
                             logic [fct_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    if (idx < fct_pkg::PLANE_COUNT) frustum[idx] = fct_pkg::plane_t'(value);
  endtask

  task automatic wait_idle();
    while (queries_to_send.size() != 0 || offer_open || inside_due.size() != 0)
      @(posedge clk);
  endtask

  // Query driver.
  int unsigned in_gap = 0;
  int unsigned in_run = 0;
  bit          in_idling = 1'b0;

  always @(posedge clk) begin : query_driver
    cull_query_t taken;
    cull_query_t next_q;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      in_gap       <= 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        taken.mode       = in_bus.mode;
        taken.corner_a_x = in_bus.corner_a_x;
        taken.corner_a_y = in_bus.corner_a_y;
        taken.corner_a_z = in_bus.corner_a_z;
        taken.corner_b_x = in_bus.corner_b_x;
        taken.corner_b_y = in_bus.corner_b_y;
        taken.corner_b_z = in_bus.corner_b_z;
        taken.radius     = in_bus.radius;
        inside_due.push_back(frustum_verdict(taken));
        offer_open = 1'b0;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (in_gap != 0) begin
          in_bus.valid <= 1'b0;
          in_gap       <= in_gap - 1;
        end else if (queries_to_send.size() != 0) begin
          next_q = queries_to_send.pop_front();
          offer_open = 1'b1;
          in_bus.valid      <= 1'b1;
          in_bus.mode       <= next_q.mode;
          in_bus.corner_a_x <= next_q.corner_a_x;
          in_bus.corner_a_y <= next_q.corner_a_y;
          in_bus.corner_a_z <= next_q.corner_a_z;
          in_bus.corner_b_x <= next_q.corner_b_x;
          in_bus.corner_b_y <= next_q.corner_b_y;
          in_bus.corner_b_z <= next_q.corner_b_z;
          in_bus.radius     <= next_q.radius;
          in_gap            <= pick_gap(in_run, in_idling);
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor; it also owns the ready side, including the long hold-offs
  // that let the block fill up and push back on its input.
  int unsigned out_gap = 0;
  int unsigned out_run = 0;
  int unsigned stall_left = 0;
  bit          out_idling = 1'b0;

  always @(posedge clk) begin : result_monitor
    bit          want;
    int unsigned nxt_gap;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      out_gap       <= 0;
      stall_left    <= 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        results_seen++;
        if (inside_due.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with none due: expected nothing, got inside_res=%0b",
                   $time, out_bus.inside_res);
        end else begin
          want = inside_due.pop_front();
          if (out_bus.inside_res !== want) begin
            fail_count++;
            $display("%0t: inside_res mismatch: expected %0b, got %0b",
                     $time, want, out_bus.inside_res);
          end
        end
      end
      if (stall_left != 0) begin
        out_bus.ready <= 1'b0;
        stall_left    <= stall_left - 1;
      end else if (out_bus.valid && out_bus.ready) begin
        if (results_seen == STALL_AT_A || results_seen == STALL_AT_B) begin
          out_bus.ready <= 1'b0;
          stall_left    <= STALL_CYCLES;
        end else begin
          nxt_gap = pick_gap(out_run, out_idling);
          out_bus.ready <= (nxt_gap == 0);
          out_gap       <= nxt_gap;
        end
      end else if (out_gap != 0) begin
        out_bus.ready <= 1'b0;
        out_gap       <= out_gap - 1;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Watchdog: the run is hung if no beat moves on any channel for too long.
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: timeout, no beat for %0d cycles", $time, QUIET_LIMIT);
      $display("frustum_cull_test verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int                             n_queries;
    logic [fct_pkg::CFG_DATA_W-1:0] setting;
    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.mode        = '0;
    in_bus.corner_a_x  = '0;
    in_bus.corner_a_y  = '0;
    in_bus.corner_a_z  = '0;
    in_bus.corner_b_x  = '0;
    in_bus.corner_b_y  = '0;
    in_bus.corner_b_z  = '0;
    in_bus.radius      = '0;
    out_bus.ready      = 1'b0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = '0;
    cfg_bus.data       = '0;
    for (int k = 0; k < fct_pkg::PLANE_COUNT; k++) frustum[k] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Planes straight out of reset are all zero: everything is rejected but a
    // sphere with some radius.
    queries_to_send.push_back(make_query(fct_pkg::MODE_POINT, 0, 0, 0, 0, 0, 0, 0));
    queries_to_send.push_back(make_query(fct_pkg::MODE_SPHERE, 0, 0, 0, 0, 0, 0, 0));
    queries_to_send.push_back(make_query(fct_pkg::MODE_SPHERE, COORD_MAX, COORD_MIN,
                                         COORD_MAX, 0, 0, 0, RAD_MAX));
    queries_to_send.push_back(make_query(fct_pkg::MODE_BOX, COORD_MIN, COORD_MIN, COORD_MIN,
                                         COORD_MAX, COORD_MAX, COORD_MAX, 0));
    queries_to_send.push_back(make_query(MODE_SPARE, UNIT, UNIT, UNIT,
                                         COORD_MAX, COORD_MIN, -1, RAD_MAX));
    wait_idle();

    // A cube of half size 100 with unit normals, plus writes to the unmapped
    // indexes, which must leave the planes alone.
    for (int k = 0; k < fct_pkg::PLANE_COUNT; k++)
      write_plane(k[fct_pkg::CFG_IDX_W-1:0], cube_plane(k, CUBE_HALF, COEF_ONE));
    write_plane(REG_SPARE_6, {$urandom, $urandom});
    write_plane(REG_SPARE_7, {$urandom, $urandom});

    queries_to_send.push_back(make_query(fct_pkg::MODE_POINT, 0, 0, 0, 0, 0, 0, 0));
    queries_to_send.push_back(make_query(fct_pkg::MODE_POINT, -100 * UNIT, 0, 0,
                                         0, 0, 0, 0));
    queries_to_send.push_back(make_query(fct_pkg::MODE_POINT, -100 * UNIT + 1, 0, 0,
                                         0, 0, 0, 0));
    queries_to_send.push_back(make_query(fct_pkg::MODE_POINT, 100 * UNIT - 1,
                                         -100 * UNIT + 1, 100 * UNIT - 1,
                                         COORD_MIN, COORD_MAX, 0, RAD_MAX));
    queries_to_send.push_back(make_query(fct_pkg::MODE_SPHERE, -150 * UNIT, 0, 0,
                                         0, 0, 0, 50 * UNIT));
    queries_to_send.push_back(make_query(fct_pkg::MODE_SPHERE, -150 * UNIT, 0, 0,
                                         0, 0, 0, 50 * UNIT + 1));
    queries_to_send.push_back(make_query(fct_pkg::MODE_SPHERE, 0, 0, 0, COORD_MAX,
                                         COORD_MAX, COORD_MAX, 0));
    queries_to_send.push_back(make_query(fct_pkg::MODE_SPHERE, COORD_MIN, COORD_MIN,
                                         COORD_MIN, 0, 0, 0, RAD_MAX));
    queries_to_send.push_back(make_query(fct_pkg::MODE_BOX, -200 * UNIT, -200 * UNIT,
                                         -200 * UNIT, 0, 0, 0, 0));
    queries_to_send.push_back(make_query(fct_pkg::MODE_BOX, 0, 0, 0, -200 * UNIT,
                                         -200 * UNIT, -200 * UNIT, RAD_MAX));
    queries_to_send.push_back(make_query(fct_pkg::MODE_BOX, 150 * UNIT, 150 * UNIT,
                                         150 * UNIT, 200 * UNIT, 200 * UNIT,
                                         200 * UNIT, 0));
    queries_to_send.push_back(make_query(fct_pkg::MODE_BOX, -300 * UNIT, 0, 0,
                                         -100 * UNIT, 10 * UNIT, 10 * UNIT, 0));
    queries_to_send.push_back(make_query(fct_pkg::MODE_BOX, 0, 0, 0, 0, 0, 0, 0));
    queries_to_send.push_back(make_query(fct_pkg::MODE_POINT, COORD_MAX, COORD_MAX,
                                         COORD_MAX, 0, 0, 0, 0));
    queries_to_send.push_back(make_query(fct_pkg::MODE_POINT, COORD_MIN, COORD_MIN,
                                         COORD_MIN, 0, 0, 0, 0));
    queries_to_send.push_back(make_query(MODE_SPARE, 0, 0, 0, COORD_MIN, COORD_MIN,
                                         COORD_MIN, 0));
    wait_idle();

    // Random part, one plane setting per round.
    for (int round = 0; round < 9; round++) begin
      for (int k = 0; k < fct_pkg::PLANE_COUNT; k++) begin
        case (round)
          0:       setting = cube_plane(k, CUBE_HALF, COEF_ONE);
          1:       setting = PLANE_ALL_ONES;
          2:       setting = PLANE_ALL_MAX;
          3:       setting = PLANE_ALL_MIN;
          default: setting = rand_plane(k);
        endcase
        write_plane(k[fct_pkg::CFG_IDX_W-1:0], setting);
      end
      n_queries = (round >= 1 && round <= 3) ? 30 : 72;
      repeat (n_queries) queries_to_send.push_back(rand_query());
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && inside_due.size() == 0) begin
      $display("frustum_cull_test verification clean");
    end else begin
      $display("frustum_cull_test verification failed");
    end
    $finish;
  end

endmodule : frustum_cull_test_tb

### filelist.f
rtl/fct_pkg.sv
rtl/fct_if.sv
rtl/fct_plane_regs.sv
rtl/fct_plane_lane.sv
rtl/frustum_cull_test.sv
tb/frustum_cull_test_tb.sv
